// ===== design/bvn_pkg.sv =====
package bvn_pkg;

  // Lattice geometry: one more point per axis than the largest cell count.
  localparam int MAX_SCALE  = 15;
  localparam int IDX_W      = 4;
  localparam int VAL_W      = 16;
  localparam int COORD_W    = 24;
  localparam int SCALE_W    = 4;
  localparam int BANK_AW    = 6;
  localparam int BANK_DEPTH = 64;
  localparam int NUM_BANKS  = 4;
  localparam int PROD_W     = 34;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 4'd2;

  // Request kinds on the input channel.
  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  // Lattice write request.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] x;
    logic [IDX_W-1:0] y;
    logic [VAL_W-1:0] value;
  } wr_req_t;

  // Bank addresses for the four corners of one cell. The lattice is split
  // into four banks by the parity of x and y, so each bank is read once.
  typedef struct packed {
    logic         x_odd;
    logic         y_odd;
    logic [2:0]   xa_even;
    logic [2:0]   xa_odd;
    logic [2:0]   ya_even;
    logic [2:0]   ya_odd;
  } rd_req_t;

  // Corner values of one cell, first index along x, second along y.
  typedef struct packed {
    logic [VAL_W-1:0] g00;
    logic [VAL_W-1:0] g01;
    logic [VAL_W-1:0] g10;
    logic [VAL_W-1:0] g11;
  } corners_t;

  // Maps the truncated signed fraction f of a Q8.16 coordinate to (f+1)/2
  // in unsigned Q0.16. The fraction keeps the sign of the coordinate.
  function automatic logic [VAL_W-1:0] unit_position(input logic [COORD_W-1:0] c);
    logic [VAL_W-1:0] frac;
    logic [VAL_W:0]   sum;
    frac = c[COORD_W-1] ? (16'd0 - c[VAL_W-1:0]) : c[VAL_W-1:0];
    sum  = c[COORD_W-1] ? (17'h10000 - {1'b0, frac}) : {1'b1, frac};
    return sum[VAL_W:1];
  endfunction

  // First half of a lerp: weight times the signed difference of the ends.
  function automatic logic signed [PROD_W-1:0] lerp_prod(input logic [VAL_W-1:0] a,
                                                         input logic [VAL_W-1:0] b,
                                                         input logic [VAL_W-1:0] w);
    logic signed [VAL_W:0] d;
    d = $signed({1'b0, b}) - $signed({1'b0, a});
    return d * $signed({1'b0, w});
  endfunction

  // Second half of a lerp: add the floored Q0.16 step to the start value.
  function automatic logic [VAL_W-1:0] lerp_sum(input logic [VAL_W-1:0]        a,
                                                input logic signed [PROD_W-1:0] p);
    logic signed [VAL_W+1:0] s;
    s = $signed({2'b00, a}) + $signed(p[PROD_W-1:VAL_W]);
    return s[VAL_W-1:0];
  endfunction

endpackage

// ===== design/bvn_coord_map.sv =====
module bvn_coord_map (
  input  logic [bvn_pkg::COORD_W-1:0] coord_u,
  input  logic [bvn_pkg::COORD_W-1:0] coord_v,
  input  logic [bvn_pkg::SCALE_W-1:0] scale,
  output bvn_pkg::rd_req_t            rd_req,
  output logic [bvn_pkg::VAL_W-1:0]   weight_u,
  output logic [bvn_pkg::VAL_W-1:0]   weight_v
);

  logic [bvn_pkg::VAL_W-1:0] pos_u;
  logic [bvn_pkg::VAL_W-1:0] pos_v;
  logic [19:0]               scaled_u;
  logic [19:0]               scaled_v;
  logic [bvn_pkg::IDX_W-1:0] cell_u;
  logic [bvn_pkg::IDX_W-1:0] cell_v;
  logic [bvn_pkg::IDX_W-1:0] next_u;
  logic [bvn_pkg::IDX_W-1:0] next_v;

  // Position in the unit square, scaled to cell index and weight.
  always_comb begin
    pos_u    = bvn_pkg::unit_position(coord_u);
    pos_v    = bvn_pkg::unit_position(coord_v);
    scaled_u = {4'd0, pos_u} * {16'd0, scale};
    scaled_v = {4'd0, pos_v} * {16'd0, scale};
    cell_u   = scaled_u[19:16];
    cell_v   = scaled_v[19:16];
    weight_u = scaled_u[15:0];
    weight_v = scaled_v[15:0];
  end

  // The cell index never exceeds scale-1, so the upper corner needs no
  // clamp; with a scale of zero both weights are zero and it is ignored.
  always_comb begin
    next_u = cell_u + 4'd1;
    next_v = cell_v + 4'd1;
    rd_req.x_odd   = cell_u[0];
    rd_req.y_odd   = cell_v[0];
    rd_req.xa_even = cell_u[0] ? next_u[3:1] : cell_u[3:1];
    rd_req.xa_odd  = cell_u[0] ? cell_u[3:1] : next_u[3:1];
    rd_req.ya_even = cell_v[0] ? next_v[3:1] : cell_v[3:1];
    rd_req.ya_odd  = cell_v[0] ? cell_v[3:1] : next_v[3:1];
  end

endmodule

// ===== design/bvn_lattice_mem.sv =====
module bvn_lattice_mem (
  input  logic              clk,
  input  bvn_pkg::wr_req_t  wr_req,
  input  logic              rd_en,
  input  bvn_pkg::rd_req_t  rd_req,
  output bvn_pkg::corners_t corners
);

  logic [bvn_pkg::VAL_W-1:0] bank_q [bvn_pkg::NUM_BANKS];
  logic                      x_odd_r;
  logic                      y_odd_r;
  logic [bvn_pkg::VAL_W-1:0] lo_y0;
  logic [bvn_pkg::VAL_W-1:0] lo_y1;
  logic [bvn_pkg::VAL_W-1:0] hi_y0;
  logic [bvn_pkg::VAL_W-1:0] hi_y1;

  // Four banks selected by x and y parity, each one write and one read port.
  for (genvar b = 0; b < bvn_pkg::NUM_BANKS; b++) begin : g_bank
    localparam logic BX = 1'((b >> 1) & 1);
    localparam logic BY = 1'(b & 1);

    logic [bvn_pkg::VAL_W-1:0]   ram [bvn_pkg::BANK_DEPTH];
    logic [bvn_pkg::VAL_W-1:0]   q_r;
    logic [bvn_pkg::BANK_AW-1:0] waddr;
    logic [bvn_pkg::BANK_AW-1:0] raddr;
    logic                        we;

    assign we    = wr_req.en && (wr_req.x[0] == BX) && (wr_req.y[0] == BY);
    assign waddr = {wr_req.x[3:1], wr_req.y[3:1]};
    assign raddr = {(BX ? rd_req.xa_odd : rd_req.xa_even),
                    (BY ? rd_req.ya_odd : rd_req.ya_even)};

    always_ff @(posedge clk) begin
      if (we) begin
        ram[waddr] <= wr_req.value;
      end
      if (rd_en) begin
        q_r <= ram[raddr];
      end
    end

    assign bank_q[b] = q_r;
  end

  // Corner parity travels with the read data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      x_odd_r <= rd_req.x_odd;
      y_odd_r <= rd_req.y_odd;
    end
  end

  // Steer bank outputs back to corner order: first swap on x, then on y.
  always_comb begin
    lo_y0 = x_odd_r ? bank_q[2] : bank_q[0];
    lo_y1 = x_odd_r ? bank_q[3] : bank_q[1];
    hi_y0 = x_odd_r ? bank_q[0] : bank_q[2];
    hi_y1 = x_odd_r ? bank_q[1] : bank_q[3];
    corners.g00 = y_odd_r ? lo_y1 : lo_y0;
    corners.g01 = y_odd_r ? lo_y0 : lo_y1;
    corners.g10 = y_odd_r ? hi_y1 : hi_y0;
    corners.g11 = y_odd_r ? hi_y0 : hi_y1;
  end

endmodule

// ===== design/bilinear_value_noise_sampler.sv =====
// Bilinear value-noise sampler.
// The input stream carries two request kinds, chosen by in_tuser. A write
// request stores a Q0.16 lattice value at (lattice_x, lattice_y) and yields
// no result. A query request takes signed Q8.16 coordinates u and v and
// yields one Q0.16 noise value on the output stream, in request order.
// The loader writes all (grid_scale+1)^2 lattice points before querying.
// The cfg stream sets grid_scale (cells per axis); write it only while idle.
// The edge that accepts a query loads the input register; the lattice bank
// read, two lerp stages and the output register follow, and the last of
// them drives out_tvalid. One request is accepted every cycle while the
// receiver does not stall: the lattice is held in four parity banks so the
// four corners of a cell are read together, and a write followed at once
// by a query of the same point sees the new value.
// Reset clears all pipeline valids and sets grid_scale to 2; the lattice
// contents are undefined until written. When the receiver stalls, results
// hold in the output register and bubbles left by write requests close up
// before the input is back-pressured.
module bilinear_value_noise_sampler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [3:0] lattice_x, [7:4] lattice_y, [23:8] lattice_value,
  // [47:24] coord_u, [71:48] coord_v
  input  logic [71:0] in_tdata,
  // [0] kind
  input  logic [0:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] noise_value
  output logic [15:0] out_tdata,
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  // [3:0] grid_scale
  input  logic [3:0]  cfg_tdata
);

  logic [bvn_pkg::SCALE_W-1:0] scale_r;

  logic                           s1_v_r;
  bvn_pkg::kind_t                 s1_kind_r;
  logic [bvn_pkg::IDX_W-1:0]      s1_x_r;
  logic [bvn_pkg::IDX_W-1:0]      s1_y_r;
  logic [bvn_pkg::VAL_W-1:0]      s1_val_r;
  logic [bvn_pkg::COORD_W-1:0]    s1_cu_r;
  logic [bvn_pkg::COORD_W-1:0]    s1_cv_r;

  logic                           s2_v_r;
  logic [bvn_pkg::VAL_W-1:0]      s2_wu_r;
  logic [bvn_pkg::VAL_W-1:0]      s2_wv_r;

  logic                           s3_v_r;
  logic [bvn_pkg::VAL_W-1:0]      s3_a0_r;
  logic [bvn_pkg::VAL_W-1:0]      s3_a1_r;
  logic signed [bvn_pkg::PROD_W-1:0] s3_p0_r;
  logic signed [bvn_pkg::PROD_W-1:0] s3_p1_r;
  logic [bvn_pkg::VAL_W-1:0]      s3_wu_r;

  logic                           s4_v_r;
  logic [bvn_pkg::VAL_W-1:0]      s4_t1_r;
  logic signed [bvn_pkg::PROD_W-1:0] s4_p_r;

  logic                           out_v_r;
  logic [bvn_pkg::VAL_W-1:0]      out_data_r;

  logic s1_rdy;
  logic s2_rdy;
  logic s3_rdy;
  logic s4_rdy;
  logic out_rdy;

  bvn_pkg::rd_req_t          rd_req;
  bvn_pkg::wr_req_t          wr_req;
  bvn_pkg::corners_t         corners;
  logic [bvn_pkg::VAL_W-1:0] weight_u;
  logic [bvn_pkg::VAL_W-1:0] weight_v;

  logic signed [bvn_pkg::PROD_W-1:0] s3_p0_nxt;
  logic signed [bvn_pkg::PROD_W-1:0] s3_p1_nxt;
  logic [bvn_pkg::VAL_W-1:0]         s4_t1_nxt;
  logic [bvn_pkg::VAL_W-1:0]         s4_t2;
  logic signed [bvn_pkg::PROD_W-1:0] s4_p_nxt;
  logic [bvn_pkg::VAL_W-1:0]         out_data_nxt;

  // Each stage moves on when it is empty or the next stage moves on.
  always_comb begin
    out_rdy = !out_v_r || out_tready;
    s4_rdy  = !s4_v_r || out_rdy;
    s3_rdy  = !s3_v_r || s4_rdy;
    s2_rdy  = !s2_v_r || s3_rdy;
    s1_rdy  = !s1_v_r || s2_rdy;
  end

  assign in_tready  = s1_rdy;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign cfg_tready = 1'b1;

  // Grid scale register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= bvn_pkg::SCALE_RESET;
    end else if (cfg_tvalid) begin
      scale_r <= cfg_tdata;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_r <= in_tvalid;
    end
    if (s1_rdy) begin
      s1_kind_r <= bvn_pkg::kind_t'(in_tuser[0]);
      s1_x_r    <= in_tdata[3:0];
      s1_y_r    <= in_tdata[7:4];
      s1_val_r  <= in_tdata[23:8];
      s1_cu_r   <= in_tdata[47:24];
      s1_cv_r   <= in_tdata[71:48];
    end
  end

  // Cell index, weights and bank addresses of a query.
  bvn_coord_map u_coord_map (
    .coord_u  (s1_cu_r),
    .coord_v  (s1_cv_r),
    .scale    (scale_r),
    .rd_req   (rd_req),
    .weight_u (weight_u),
    .weight_v (weight_v)
  );

  // Writes commit as they leave the input register, in order with reads.
  always_comb begin
    wr_req.en    = s1_v_r && (s1_kind_r == bvn_pkg::KIND_WRITE) && s2_rdy;
    wr_req.x     = s1_x_r;
    wr_req.y     = s1_y_r;
    wr_req.value = s1_val_r;
  end

  bvn_lattice_mem u_lattice_mem (
    .clk     (clk),
    .wr_req  (wr_req),
    .rd_en   (s2_rdy),
    .rd_req  (rd_req),
    .corners (corners)
  );

  // Read stage: only queries go on, writes leave a bubble.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_rdy) begin
      s2_v_r <= s1_v_r && (s1_kind_r == bvn_pkg::KIND_QUERY);
    end
    if (s2_rdy) begin
      s2_wu_r <= weight_u;
      s2_wv_r <= weight_v;
    end
  end

  // Lerp along v, products registered.
  always_comb begin
    s3_p0_nxt = bvn_pkg::lerp_prod(corners.g00, corners.g01, s2_wv_r);
    s3_p1_nxt = bvn_pkg::lerp_prod(corners.g10, corners.g11, s2_wv_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_rdy) begin
      s3_v_r <= s2_v_r;
    end
    if (s3_rdy) begin
      s3_a0_r <= corners.g00;
      s3_a1_r <= corners.g10;
      s3_p0_r <= s3_p0_nxt;
      s3_p1_r <= s3_p1_nxt;
      s3_wu_r <= s2_wu_r;
    end
  end

  // Finish the v lerps and form the product of the u lerp.
  always_comb begin
    s4_t1_nxt = bvn_pkg::lerp_sum(s3_a0_r, s3_p0_r);
    s4_t2     = bvn_pkg::lerp_sum(s3_a1_r, s3_p1_r);
    s4_p_nxt  = bvn_pkg::lerp_prod(s4_t1_nxt, s4_t2, s3_wu_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (s4_rdy) begin
      s4_v_r <= s3_v_r;
    end
    if (s4_rdy) begin
      s4_t1_r <= s4_t1_nxt;
      s4_p_r  <= s4_p_nxt;
    end
  end

  // Output register.
  assign out_data_nxt = bvn_pkg::lerp_sum(s4_t1_r, s4_p_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_rdy) begin
      out_v_r <= s4_v_r;
    end
    if (out_rdy) begin
      out_data_r <= out_data_nxt;
    end
  end

  // A write request leaving the input register never becomes a result.
  a_write_drops: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && (s1_kind_r == bvn_pkg::KIND_WRITE) && s2_rdy |=> !s2_v_r)
    else $error("write request entered the read stage as valid");

  // A query leaving the input register is not lost.
  a_query_kept: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && (s1_kind_r == bvn_pkg::KIND_QUERY) && s2_rdy |=> s2_v_r)
    else $error("query lost between input register and read stage");

  // A stalled final lerp stage keeps its contents.
  a_s4_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s4_v_r && !s4_rdy |=> s4_v_r && $stable(s4_t1_r) && $stable(s4_p_r))
    else $error("final lerp stage overwritten while stalled");

  // With the output register empty the whole pipeline can take a request.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r |-> in_tready)
    else $error("input stalled with empty output register");

endmodule
